// ===== sv/tspc_pkg.sv =====
`timescale 1ns / 1ps

package tspc_pkg;

  localparam logic [1:0] OP_CLASSIFY = 2'd0;
  localparam logic [1:0] OP_BEGIN    = 2'd1;
  localparam logic [1:0] OP_ADD      = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_GROUPS_FULL = 2'd1;
  localparam logic [1:0] ST_RULES_FULL  = 2'd2;
  localparam logic [1:0] ST_ORDER       = 2'd3;

  localparam logic [31:0] MASK_24 = 32'h00ff_ffff;
  localparam logic [31:0] MASK_16 = 32'h0000_ffff;
  localparam logic [31:0] MASK_8  = 32'h0000_00ff;
  localparam logic [31:0] MASK_0  = 32'h0000_0000;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
  } key_t;

  typedef struct packed {
    logic deny;
    key_t key;
  } rule_t;

endpackage

// ===== sv/tspc_match.sv =====
`timescale 1ns / 1ps

module tspc_match
  import tspc_pkg::*;
(
  input  key_t  pkt,
  input  rule_t rule_rec,
  output logic  match
);

  logic m_sip;
  logic m_dip;
  logic m_sport;
  logic m_dport;
  logic m_proto;

  // zero rule field is a wildcard
  assign m_sip   = (rule_rec.key.src_ip == '0)   || (rule_rec.key.src_ip == pkt.src_ip);
  assign m_dip   = (rule_rec.key.dst_ip == '0)   || (rule_rec.key.dst_ip == pkt.dst_ip);
  assign m_sport = (rule_rec.key.src_port == '0) || (rule_rec.key.src_port == pkt.src_port);
  assign m_dport = (rule_rec.key.dst_port == '0) || (rule_rec.key.dst_port == pkt.dst_port);
  assign m_proto = (rule_rec.key.protocol == '0) || (rule_rec.key.protocol == pkt.protocol);

  assign match = m_sip & m_dip & m_sport & m_dport & m_proto;

endmodule

// ===== sv/tuple_space_packet_classifier.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  opcode, ips, ports, protocol, deny, prefix lengths
// out_     output     out_valid/out_stall verdict, hit, status
//
// Load items (begin group, add rule) pass through the execute and done states to the output register.
// Classify reads each closed group's prefix lengths and rule count, then scans its rules until the first match;
// the rule memory delivers one rule per cycle to the shared match unit.
// in_stall is high from acceptance until the result moves to the output register.
// Reset (rst_n low, synchronous) empties the group table; stores need no clearing.
// A stalled result holds in the output register while the next transaction is taken.

module tuple_space_packet_classifier
  import tspc_pkg::*;
#(
  parameter int MAX_GROUPS      = 8,
  parameter int RULES_PER_GROUP = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_protocol,
  input  logic        in_deny,
  input  logic [5:0]  in_src_prefix_len,
  input  logic [5:0]  in_dst_prefix_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_verdict,
  output logic        out_hit,
  output logic [1:0]  out_status
);

  localparam int TOTAL = MAX_GROUPS * RULES_PER_GROUP;
  localparam int GCW   = $clog2(MAX_GROUPS + 1);
  localparam int GIW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int RCW   = $clog2(RULES_PER_GROUP + 1);
  localparam int SCW   = $clog2(TOTAL + 1);
  localparam int SW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_GRD  = 3'd2;
  localparam logic [2:0] S_GLD  = 3'd3;
  localparam logic [2:0] S_RRD  = 3'd4;
  localparam logic [2:0] S_RCMP = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  function automatic logic [31:0] apply_prefix(input logic [31:0] addr, input logic [5:0] len);
    logic [31:0] res;
    case (len)
      6'd24:   res = addr & MASK_24;
      6'd16:   res = addr & MASK_16;
      6'd8:    res = addr & MASK_8;
      6'd0:    res = addr & MASK_0;
      default: res = addr;
    endcase
    return res;
  endfunction

  logic [2:0]     state_r, state_nxt;
  logic [GCW-1:0] closed_r, closed_nxt;
  logic           open_r, open_nxt;
  logic [RCW-1:0] orc_r, orc_nxt;
  logic [SCW-1:0] obase_r, obase_nxt;

  logic [1:0]     op_r, op_nxt;
  rule_t          item_r, item_nxt;
  logic [5:0]     slen_r, slen_nxt;
  logic [5:0]     dlen_r, dlen_nxt;
  key_t           key_r, key_nxt;
  logic [GCW-1:0] g_r, g_nxt;
  logic [SCW-1:0] gbase_r, gbase_nxt;
  logic [SCW-1:0] slot_r, slot_nxt;
  logic [RCW-1:0] r_r, r_nxt;
  logic [RCW-1:0] n_r, n_nxt;
  logic           res_verdict_r, res_verdict_nxt;
  logic           res_hit_r, res_hit_nxt;
  logic [1:0]     res_status_r, res_status_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_verdict_r, out_verdict_nxt;
  logic           out_hit_r, out_hit_nxt;
  logic [1:0]     out_status_r, out_status_nxt;

  logic [11:0]    gpl_mem [MAX_GROUPS];
  logic [RCW-1:0] gcnt_mem [MAX_GROUPS];
  rule_t          rule_mem [TOTAL];
  logic [11:0]    gpl_q;
  logic [RCW-1:0] gcnt_q;
  rule_t          rule_q;

  logic           gpl_we;
  logic           gcnt_we;
  logic           rule_we;
  logic           gmem_re;
  logic           rule_re;
  logic [SW-1:0]  rule_raddr;
  logic [SCW-1:0] wr_slot;
  logic [SCW-1:0] slot_inc;
  logic [RCW:0]   r_inc;
  logic           match;

  assign wr_slot  = obase_r + SCW'(orc_r);
  assign slot_inc = slot_r + SCW'(1);
  assign r_inc    = {1'b0, r_r} + (RCW + 1)'(1);

  tspc_match u_match (
    .pkt      (key_r),
    .rule_rec (rule_q),
    .match    (match)
  );

  always_ff @(posedge clk) begin
    if (gpl_we) begin
      gpl_mem[closed_r[GIW-1:0]] <= {dlen_r, slen_r};
    end
    if (gcnt_we) begin
      gcnt_mem[closed_r[GIW-1:0]] <= orc_r;
    end
    if (gmem_re) begin
      gpl_q  <= gpl_mem[g_r[GIW-1:0]];
      gcnt_q <= gcnt_mem[g_r[GIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rule_we) begin
      rule_mem[wr_slot[SW-1:0]] <= item_r;
    end
    if (rule_re) begin
      rule_q <= rule_mem[rule_raddr];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    closed_nxt      = closed_r;
    open_nxt        = open_r;
    orc_nxt         = orc_r;
    obase_nxt       = obase_r;
    op_nxt          = op_r;
    item_nxt        = item_r;
    slen_nxt        = slen_r;
    dlen_nxt        = dlen_r;
    key_nxt         = key_r;
    g_nxt           = g_r;
    gbase_nxt       = gbase_r;
    slot_nxt        = slot_r;
    r_nxt           = r_r;
    n_nxt           = n_r;
    res_verdict_nxt = res_verdict_r;
    res_hit_nxt     = res_hit_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r & out_stall;
    out_verdict_nxt = out_verdict_r;
    out_hit_nxt     = out_hit_r;
    out_status_nxt  = out_status_r;
    gpl_we          = 1'b0;
    gcnt_we         = 1'b0;
    rule_we         = 1'b0;
    gmem_re         = 1'b0;
    rule_re         = 1'b0;
    rule_raddr      = slot_r[SW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt                = in_opcode;
          item_nxt.deny         = in_deny;
          item_nxt.key.src_ip   = in_src_ip;
          item_nxt.key.dst_ip   = in_dst_ip;
          item_nxt.key.src_port = in_src_port;
          item_nxt.key.dst_port = in_dst_port;
          item_nxt.key.protocol = in_protocol;
          slen_nxt              = in_src_prefix_len;
          dlen_nxt              = in_dst_prefix_len;
          res_verdict_nxt       = 1'b0;
          res_hit_nxt           = 1'b0;
          res_status_nxt        = ST_OK;
          if (in_opcode == OP_CLASSIFY) begin
            g_nxt     = '0;
            gbase_nxt = '0;
            state_nxt = S_GRD;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_BEGIN: begin
            if (open_r) begin
              res_status_nxt = ST_ORDER;
            end else if (closed_r >= GCW'(MAX_GROUPS)) begin
              res_status_nxt = ST_GROUPS_FULL;
            end else begin
              gpl_we   = 1'b1;
              open_nxt = 1'b1;
              orc_nxt  = '0;
            end
          end
          OP_ADD: begin
            if (!open_r || closed_r >= GCW'(MAX_GROUPS)) begin
              res_status_nxt = ST_ORDER;
            end else if (item_r.key == '0) begin
              gcnt_we    = 1'b1;
              closed_nxt = closed_r + GCW'(1);
              open_nxt   = 1'b0;
              orc_nxt    = '0;
              obase_nxt  = obase_r + SCW'(RULES_PER_GROUP);
            end else if (orc_r >= RCW'(RULES_PER_GROUP)) begin
              res_status_nxt = ST_RULES_FULL;
            end else begin
              rule_we = 1'b1;
              orc_nxt = orc_r + RCW'(1);
            end
          end
          default: begin
          end
        endcase
        state_nxt = S_DONE;
      end
      S_GRD: begin
        if (g_r == closed_r) begin
          state_nxt = S_DONE;
        end else begin
          gmem_re   = 1'b1;
          slot_nxt  = gbase_r;
          gbase_nxt = gbase_r + SCW'(RULES_PER_GROUP);
          state_nxt = S_GLD;
        end
      end
      S_GLD: begin
        key_nxt        = item_r.key;
        key_nxt.src_ip = apply_prefix(item_r.key.src_ip, gpl_q[5:0]);
        key_nxt.dst_ip = apply_prefix(item_r.key.dst_ip, gpl_q[11:6]);
        n_nxt          = gcnt_q;
        r_nxt          = '0;
        state_nxt      = S_RRD;
      end
      S_RRD: begin
        if (r_r == n_r) begin
          g_nxt     = g_r + GCW'(1);
          state_nxt = S_GRD;
        end else begin
          rule_re   = 1'b1;
          state_nxt = S_RCMP;
        end
      end
      S_RCMP: begin
        if (match) begin
          res_hit_nxt     = 1'b1;
          res_verdict_nxt = rule_q.deny;
          state_nxt       = S_DONE;
        end else if (r_inc < {1'b0, n_r}) begin
          rule_re    = 1'b1;
          rule_raddr = slot_inc[SW-1:0];
          slot_nxt   = slot_inc;
          r_nxt      = r_inc[RCW-1:0];
        end else begin
          g_nxt     = g_r + GCW'(1);
          state_nxt = S_GRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = res_verdict_r;
          out_hit_nxt     = res_hit_r;
          out_status_nxt  = res_status_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      closed_r    <= '0;
      open_r      <= 1'b0;
      orc_r       <= '0;
      obase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      closed_r    <= closed_nxt;
      open_r      <= open_nxt;
      orc_r       <= orc_nxt;
      obase_r     <= obase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    item_r        <= item_nxt;
    slen_r        <= slen_nxt;
    dlen_r        <= dlen_nxt;
    key_r         <= key_nxt;
    g_r           <= g_nxt;
    gbase_r       <= gbase_nxt;
    slot_r        <= slot_nxt;
    r_r           <= r_nxt;
    n_r           <= n_nxt;
    res_verdict_r <= res_verdict_nxt;
    res_hit_r     <= res_hit_nxt;
    res_status_r  <= res_status_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_hit_r     <= out_hit_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;
  assign out_hit     = out_hit_r;
  assign out_status  = out_status_r;

  a_open_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (closed_r < GCW'(MAX_GROUPS)))
    else $error("open group beyond group table");

  a_rule_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    orc_r <= RCW'(RULES_PER_GROUP))
    else $error("open group rule count overflow");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted transaction not started");

  a_hit_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_hit || out_verdict)) |-> (out_hit && out_status == ST_OK))
    else $error("verdict without hit or with load status");

endmodule
